[rtl/core/wpsc_pkg.sv]
// ----------------------------------------------------------------------------
// Window pair-sum checker package
// Shared widths, constants and the command and status types that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package wpsc_pkg;

    localparam int VALUE_W = 64;
    localparam int CFG_W   = 6;
    localparam int USER_W  = 2;

    localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 6'd25;

    // Cycles from the last outer-entry issue until the hit flag is settled.
    typedef logic [1:0] t_drain_cnt;
    localparam t_drain_cnt DRAIN_LAST = 2'd3;

    typedef struct packed {
        logic load;
        logic issue;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_needed;
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/core/wpsc_ctrl.sv]
// ----------------------------------------------------------------------------
// Window pair-sum checker controller
// Sequences one item at a time: load, optional window scan, pipeline drain
// and hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module wpsc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  wpsc_pkg::t_dp_status i_status,
    output wpsc_pkg::t_dp_cmd    o_cmd
);
    import wpsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state     r_state;
    t_state     n_state;
    t_drain_cnt r_drain;
    t_drain_cnt n_drain;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_drain       = r_drain;
        o_cmd.load    = 1'b0;
        o_cmd.issue   = 1'b0;
        o_cmd.publish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.scan_needed) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                    n_drain = '0;
                end
            end
            S_DRAIN: begin
                if (r_drain == DRAIN_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_drain = r_drain + 1'b1;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

`ifndef ASSERT_OFF
    a_issue_only_scanning : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_state == S_SCAN) && !o_in_ready)
        else $error("outer entry issued outside the scan");
    a_load_leads_to_check : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_CHECK) && !o_in_ready)
        else $error("accepted item not followed by the check step");
    a_publish_returns_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |=> o_in_ready)
        else $error("block not ready after publishing a result");
`endif

endmodule

[rtl/core/wpsc_datapath.sv]
// ----------------------------------------------------------------------------
// Window pair-sum checker datapath
// Holds the window as a shift line, the length register, the fill count,
// the four-stage compare pipeline and the output register.
// ----------------------------------------------------------------------------
module wpsc_datapath #(
    parameter int WINDOW_MAX = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [wpsc_pkg::CFG_W-1:0]        i_cfg_wr_data,
    input  logic [wpsc_pkg::VALUE_W-1:0]      i_in_data,
    input  wpsc_pkg::t_dp_cmd                 i_cmd,
    output wpsc_pkg::t_dp_status              o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [wpsc_pkg::VALUE_W-1:0]      o_out_data,
    output logic [wpsc_pkg::USER_W-1:0]       o_out_user
);
    import wpsc_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int LW1   = LEN_W + 1;

    logic [CFG_W-1:0]   r_window_len;
    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W-1:0]   r_fill;
    logic [VALUE_W-1:0] r_tap [0:WINDOW_MAX-1];
    logic [VALUE_W-1:0] r_value;
    logic               r_checked;
    logic               r_found;
    logic [IDX_W-1:0]   r_a;
    logic [VALUE_W-1:0] r_x;
    logic [IDX_W-1:0]   r_a1;
    logic               r_v1;
    logic [VALUE_W-1:0] r_d;
    logic [IDX_W-1:0]   r_a2;
    logic               r_v2;
    logic [WINDOW_MAX-1:0] r_match;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_data;
    logic [USER_W-1:0]  r_out_user;

    always_comb begin
        if (r_window_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (CMP_W'(r_window_len) > CMP_W'(WINDOW_MAX)) begin
            eff_len = LEN_W'(WINDOW_MAX);
        end else begin
            eff_len = LEN_W'(r_window_len);
        end
    end

    assign o_status.scan_needed = r_checked && (eff_len > LEN_W'(1));
    assign o_status.scan_last   = ((LW1'(r_a) + LW1'(2)) == LW1'(eff_len));
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= WINDOW_LEN_RESET;
            r_fill       <= '0;
            r_checked    <= 1'b0;
            r_found      <= 1'b0;
            r_a          <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_match      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window_len <= i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                r_checked <= (r_fill >= eff_len);
                r_found   <= 1'b0;
                r_a       <= '0;
            end else begin
                if (i_cmd.issue) begin
                    r_a <= r_a + 1'b1;
                end
                r_found <= r_found | (|r_match);
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            for (int b = 0; b < WINDOW_MAX; b++) begin
                r_match[b] <= r_v2 && (r_d == r_tap[b]) && (IDX_W'(b) > r_a2)
                              && (LEN_W'(b) < eff_len);
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
                if (r_fill != LEN_W'(WINDOW_MAX)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_in_data;
        end
        r_x  <= r_tap[r_a];
        r_a1 <= r_a;
        r_d  <= r_value - r_x;
        r_a2 <= r_a1;
        if (i_cmd.publish) begin
            r_out_data <= r_value;
            r_out_user <= {r_checked & r_found, r_checked};
            r_tap[0]   <= r_value;
            for (int k = 1; k < WINDOW_MAX; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

`ifndef ASSERT_OFF
    a_publish_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> o_status.out_free)
        else $error("result published over an untaken result");
    a_publish_drained : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.publish |-> !r_v1 && !r_v2 && (r_match == '0))
        else $error("result published before the compare pipeline drained");
    a_found_needs_check : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> r_checked)
        else $error("pair found for an unchecked item");
    a_fill_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW1'(r_fill) <= LW1'(WINDOW_MAX))
        else $error("fill count beyond the window depth");
`endif

endmodule

[rtl/core/window_pair_sum_checker.sv]
// ----------------------------------------------------------------------------
// Window pair-sum checker
// Checks each value of a 64-bit stream against the pairwise sums of the
// values just before it.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis channel, one 64-bit value per item. Each
// item yields exactly one result item on the m_axis channel: the value is
// echoed in tdata, tuser bit 0 says whether it was checked and tuser bit 1
// whether two distinct window entries sum to it modulo 2^64.
// The window length is written through i_cfg_wr_en and i_cfg_wr_data while
// the block is idle; zero acts as one and values above WINDOW_MAX act as
// WINDOW_MAX. Until that many values have been stored, results are unchecked.
// One item is processed at a time. An unchecked item, or a window of one,
// goes from the check step straight to the result register; a checked
// item is scanned first, one outer window entry per cycle being fed through a
// four-stage compare pipeline against all entries in parallel, and the
// pipeline is drained before the result is registered.
// The next item is accepted the cycle after the result is registered, even
// while that result still waits. If the receiver stalls, the block holds the
// next finished result until the output register frees.
// Reset clears the fill count, the output valid and sets the length to 25.
// ----------------------------------------------------------------------------
module window_pair_sum_checker #(
    parameter int WINDOW_MAX = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [wpsc_pkg::CFG_W-1:0]        i_cfg_wr_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [wpsc_pkg::VALUE_W-1:0]      i_s_axis_tdata,   // [63:0] value
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [wpsc_pkg::VALUE_W-1:0]      o_m_axis_tdata,   // [63:0] echo_value
    output logic [wpsc_pkg::USER_W-1:0]       o_m_axis_tuser    // [0] checked, [1] is_pair_sum
);
    import wpsc_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    wpsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wpsc_datapath #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_s_axis_tdata),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_data    (o_m_axis_tdata),
        .o_out_user    (o_m_axis_tuser)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window pair-sum checker testbench
// Streams 64-bit values into the checker and predicts each result item from
// a private copy of the ring, the fill count and the window length. A short
// directed run covers the length extremes, wrapping sums and equal values,
// then random phases mix true pair sums, near misses and noise under random
// idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
module testbench;

    import wpsc_pkg::*;

    localparam int RING_DEPTH  = 32;
    localparam int SLOT_W      = $clog2(RING_DEPTH);
    localparam int ITEM_TARGET = 1600;
    localparam int LONG_HOLD   = 300;
    localparam int LIMIT_NS    = 10_000_000;

    localparam logic [CFG_W-1:0] LEN_PLAN [9] = '{
        6'd32, 6'd2, 6'd1, 6'd0, 6'd63, 6'd25, 6'd31, 6'd33, 6'd3
    };

    typedef struct packed {
        logic               checked;
        logic               is_pair_sum;
        logic [VALUE_W-1:0] echo_value;
    } t_pair_sum_result;

    class pair_sum_tracker;
        bit [VALUE_W-1:0]  ring [RING_DEPTH];
        int unsigned       write_slot;
        int unsigned       fill_count;
        logic [CFG_W-1:0]  window_len;
        t_pair_sum_result  pending_results [$];
        int unsigned       errors;

        function new();
            write_slot = 0;
            fill_count = 0;
            window_len = WINDOW_LEN_RESET;
            errors     = 0;
        endfunction

        function void set_window_len(input logic [CFG_W-1:0] len);
            window_len = len;
        endfunction

        function int unsigned span();
            if (window_len == 0) begin
                return 1;
            end
            if (32'(window_len) > RING_DEPTH) begin
                return RING_DEPTH;
            end
            return 32'(window_len);
        endfunction

        function bit [VALUE_W-1:0] recent(input int unsigned k);
            return ring[SLOT_W'((write_slot + RING_DEPTH - 1 - k) % RING_DEPTH)];
        endfunction

        function bit has_pair(input logic [VALUE_W-1:0] target, input int unsigned n);
            int unsigned a;
            int unsigned b;
            bit [VALUE_W-1:0] total;
            for (a = 0; a < n; a++) begin
                for (b = a + 1; b < n; b++) begin
                    total = recent(a) + recent(b);
                    if (total == target) begin
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void note_input(input logic [VALUE_W-1:0] v);
            t_pair_sum_result res;
            int unsigned n;
            n = span();
            res.echo_value  = v;
            res.checked     = (fill_count >= n);
            res.is_pair_sum = res.checked && has_pair(v, n);
            pending_results.push_back(res);
            ring[SLOT_W'(write_slot)] = v;
            write_slot = (write_slot + 1) % RING_DEPTH;
            if (fill_count < RING_DEPTH) begin
                fill_count++;
            end
        endfunction

        function void check_result(input logic [VALUE_W-1:0] data,
                                   input logic [USER_W-1:0] user);
            t_pair_sum_result want;
            if (pending_results.size() == 0) begin
                $error("result item with no input pending: echo_value %h", data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (user[0] !== want.checked) begin
                $error("checked: expected %0b, actual %0b", want.checked, user[0]);
                errors++;
            end
            if (user[1] !== want.is_pair_sum) begin
                $error("is_pair_sum: expected %0b, actual %0b", want.is_pair_sum, user[1]);
                errors++;
            end
            if (data !== want.echo_value) begin
                $error("echo_value: expected %h, actual %h", want.echo_value, data);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_W-1:0]     i_cfg_wr_data;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [VALUE_W-1:0]   i_s_axis_tdata;    // [63:0] value
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [VALUE_W-1:0]   o_m_axis_tdata;    // [63:0] echo_value
    logic [USER_W-1:0]    o_m_axis_tuser;    // [0] checked, [1] is_pair_sum

    pair_sum_tracker board;
    int unsigned     items_sent;
    bit              sender_idles;
    int unsigned     recv_stall_pct;
    int unsigned     long_hold_requests;

    window_pair_sum_checker #(
        .WINDOW_MAX(RING_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_m_axis_tvalid && i_m_axis_tready) begin
            board.check_result(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    // The receiver stalls at random, and for one long stretch on request so
    // that the block backs up and refuses further input items.
    initial begin : receiver
        int unsigned hold_left;
        int unsigned holds_served;
        hold_left       = 0;
        holds_served    = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != long_hold_requests) begin
                holds_served = long_hold_requests;
                hold_left    = LONG_HOLD;
            end else if (hold_left == 0 && $urandom_range(0, 99) < recv_stall_pct) begin
                hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(1, 3);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("window_pair_sum_checker test failed");
        $finish;
    end

    task automatic send_value(input logic [VALUE_W-1:0] v);
        int unsigned r;
        int unsigned gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= v;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        board.note_input(v);
        items_sent++;
        gap = 0;
        if (sender_idles) begin
            r = $urandom_range(0, 99);
            if (r >= 95) begin
                gap = $urandom_range(10, 40);
            end else if (r >= 65) begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_window_len(input logic [CFG_W-1:0] len);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        board.set_window_len(len);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Often sums of two entries of the current window, some near misses,
    // repeats of stored values and plain noise.
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned n;
        int unsigned a;
        int unsigned b;
        int unsigned r;
        logic [VALUE_W-1:0] v;
        n = board.span();
        r = $urandom_range(0, 99);
        if (board.fill_count >= n && n >= 2 && r < 45) begin
            a = $urandom_range(0, n - 1);
            b = $urandom_range(0, n - 2);
            if (b >= a) begin
                b++;
            end
            v = board.recent(a) + board.recent(b);
            if ($urandom_range(0, 9) == 0) begin
                v = v + 64'd1;
            end
        end else if (board.fill_count > 0 && r < 60) begin
            v = board.recent($urandom_range(0, board.fill_count - 1));
        end else if (r < 75) begin
            v = 64'($urandom_range(0, 15));
        end else if (r < 82) begin
            v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 15));
        end else begin
            v = {$urandom, $urandom};
        end
        return v;
    endfunction

    initial begin : stimulus
        int unsigned phase;
        int unsigned count;
        int unsigned i;
        bit quiet;
        logic [CFG_W-1:0] len;

        board              = new();
        items_sent         = 0;
        sender_idles       = 1'b1;
        recv_stall_pct     = 20;
        long_hold_requests = 0;
        i_rst_n            = 1'b0;
        i_cfg_wr_en        = 1'b0;
        i_cfg_wr_data      = '0;
        i_s_axis_tvalid    = 1'b0;
        i_s_axis_tdata     = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset length: these only fill the ring.
        send_value(64'h0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        wait_for_results();

        // Window of two: wrapping sums and equal values at different positions.
        write_window_len(6'd2);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h0);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'd7);
        send_value(64'd7);
        send_value(64'd14);
        wait_for_results();

        // Zero acts as a window of one, so no pair can exist.
        write_window_len(6'd0);
        send_value(64'd21);
        send_value(64'd21);
        send_value(64'd0);
        wait_for_results();

        write_window_len(6'd1);
        send_value(64'd42);
        send_value(64'd84);
        wait_for_results();

        // Lengths above the ring size act as the full ring, and a length beyond
        // the fill count leaves items unchecked until the ring has filled.
        write_window_len(6'd33);
        send_value(64'h0000_0001_0000_0000);
        send_value(64'h5555_5555_5555_5555);
        send_value(64'hAAAA_AAAA_AAAA_AAAA);
        wait_for_results();

        write_window_len(6'd63);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        send_value(64'd1);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_for_results();
            if (phase < $size(LEN_PLAN)) begin
                len = LEN_PLAN[phase];
            end else if ($urandom_range(0, 4) == 0) begin
                len = CFG_W'($urandom_range(0, 63));
            end else begin
                len = CFG_W'($urandom_range(1, RING_DEPTH));
            end
            write_window_len(len);
            quiet          = (phase % 4 == 3);
            sender_idles   = !quiet;
            recv_stall_pct = quiet ? 0 : $urandom_range(5, 30);
            if (phase == 2) begin
                long_hold_requests++;
            end
            count = $urandom_range(40, 100);
            for (i = 0; i < count; i++) begin
                if (phase == 5 && i == count / 2) begin
                    wait_for_results();
                end
                send_value(pick_value());
            end
            phase++;
        end

        wait_for_results();
        repeat (RING_DEPTH + 8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("window_pair_sum_checker test passed");
        end else begin
            $display("window_pair_sum_checker test failed");
        end
        $finish;
    end

endmodule
